FILE: rtl/core/cbz_pkg.sv
// Shared types, constants and reset values for the cubic Bezier point evaluator.
`default_nettype none

package cbz_pkg;

	localparam int CBZ_COORD_WIDTH     = 16;
	localparam int CBZ_PARAM_FRAC_BITS = 16;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_P0_X,
		REG_P0_Y,
		REG_P1_X,
		REG_P1_Y,
		REG_P2_X,
		REG_P2_Y,
		REG_P3_X,
		REG_P3_Y
	} reg_idx_t;

	localparam int P0_X_RST = -250;
	localparam int P0_Y_RST = 250;
	localparam int P1_X_RST = -100;
	localparam int P1_Y_RST = -100;
	localparam int P2_X_RST = 100;
	localparam int P2_Y_RST = -100;
	localparam int P3_X_RST = 250;
	localparam int P3_Y_RST = 250;

	// per-stage load enables of the evaluation pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	function automatic int coord_rst(reg_idx_t idx);
		int val;
		unique case (idx)
			REG_P0_X: val = P0_X_RST;
			REG_P0_Y: val = P0_Y_RST;
			REG_P1_X: val = P1_X_RST;
			REG_P1_Y: val = P1_Y_RST;
			REG_P2_X: val = P2_X_RST;
			REG_P2_Y: val = P2_Y_RST;
			REG_P3_X: val = P3_X_RST;
			REG_P3_Y: val = P3_Y_RST;
			default:  val = 0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbz_cfg_regs.sv
// APB register file holding the four control points.
`default_nettype none

module cbz_cfg_regs #(
	parameter int COORD_WIDTH = cbz_pkg::CBZ_COORD_WIDTH
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      psel,
	input  wire logic                                      penable,
	input  wire logic                                      pwrite,
	input  wire logic [cbz_pkg::APB_ADDR_W-1:0]            paddr,
	input  wire logic [cbz_pkg::APB_DATA_W-1:0]            pwdata,
	output logic      [cbz_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                           pready,
	output logic      [3:0][COORD_WIDTH-1:0]               coord_x,
	output logic      [3:0][COORD_WIDTH-1:0]               coord_y
);

	logic signed [COORD_WIDTH-1:0] coord_q [cbz_pkg::NUM_REGS];
	cbz_pkg::reg_idx_t             idx;
	logic                          wr_en;

	assign idx    = cbz_pkg::reg_idx_t'(paddr[cbz_pkg::REG_IDX_W+1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbz_pkg::NUM_REGS; i++) begin
				coord_q[i] <= COORD_WIDTH'(cbz_pkg::coord_rst(cbz_pkg::reg_idx_t'(i)));
			end
		end else if (wr_en) begin
			coord_q[idx] <= pwdata[COORD_WIDTH-1:0];
		end
	end

	assign prdata = cbz_pkg::APB_DATA_W'(coord_q[idx]);

	assign coord_x[0] = coord_q[cbz_pkg::REG_P0_X];
	assign coord_x[1] = coord_q[cbz_pkg::REG_P1_X];
	assign coord_x[2] = coord_q[cbz_pkg::REG_P2_X];
	assign coord_x[3] = coord_q[cbz_pkg::REG_P3_X];
	assign coord_y[0] = coord_q[cbz_pkg::REG_P0_Y];
	assign coord_y[1] = coord_q[cbz_pkg::REG_P1_Y];
	assign coord_y[2] = coord_q[cbz_pkg::REG_P2_Y];
	assign coord_y[3] = coord_q[cbz_pkg::REG_P3_Y];

endmodule

`default_nettype wire

FILE: rtl/core/cbz_weight_gen.sv
// Stages 1-2: Bernstein weights u^3, 3u^2t, 3ut^2, t^3 at scale 2^(3F).
`default_nettype none

module cbz_weight_gen #(
	parameter int PARAM_FRAC_BITS = cbz_pkg::CBZ_PARAM_FRAC_BITS,
	localparam int WW = 3*PARAM_FRAC_BITS + 1
) (
	input  wire logic                           clk,
	input  wire cbz_pkg::pipe_en_t              en,
	input  wire logic [PARAM_FRAC_BITS-1:0]     curve_param,
	output logic      [3:0][WW-1:0]             weight
);

	localparam int F   = PARAM_FRAC_BITS;
	localparam int UW  = F + 1;
	localparam int TSW = 2*F;
	localparam int USW = 2*F + 1;
	localparam int MW  = F + 2;
	localparam logic [UW-1:0] U_ONE = UW'(1) << F;

	logic [UW-1:0]  u_c;

	logic [F-1:0]   t_s1;
	logic [UW-1:0]  u_s1;
	logic [TSW-1:0] tt_s1;
	logic [USW-1:0] uu_s1;
	logic [MW-1:0]  t3_s1;
	logic [MW-1:0]  u3_s1;

	logic [3:0][WW-1:0] weight_s2;

	assign u_c = U_ONE - UW'(curve_param);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1  <= curve_param;
			u_s1  <= u_c;
			tt_s1 <= TSW'(curve_param) * TSW'(curve_param);
			uu_s1 <= USW'(u_c) * USW'(u_c);
			t3_s1 <= (MW'(curve_param) << 1) + MW'(curve_param);
			u3_s1 <= (MW'(u_c) << 1) + MW'(u_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			weight_s2[0] <= WW'(uu_s1) * WW'(u_s1);
			weight_s2[1] <= WW'(uu_s1) * WW'(t3_s1);
			weight_s2[2] <= WW'(tt_s1) * WW'(u3_s1);
			weight_s2[3] <= WW'(tt_s1) * WW'(t_s1);
		end
	end

	assign weight = weight_s2;

endmodule

`default_nettype wire

FILE: rtl/core/cbz_axis_sum.sv
// Stages 3-6: weighted sum of four control coordinates for one axis, with rounding.
`default_nettype none

module cbz_axis_sum #(
	parameter int COORD_WIDTH     = cbz_pkg::CBZ_COORD_WIDTH,
	parameter int PARAM_FRAC_BITS = cbz_pkg::CBZ_PARAM_FRAC_BITS,
	localparam int WW = 3*PARAM_FRAC_BITS + 1
) (
	input  wire logic                              clk,
	input  wire cbz_pkg::pipe_en_t                 en,
	input  wire logic [3:0][COORD_WIDTH-1:0]       coord,
	input  wire logic [3:0][WW-1:0]                weight,
	output logic      [COORD_WIDTH-1:0]            point
);

	localparam int CW = COORD_WIDTH;
	localparam int SH = 3*PARAM_FRAC_BITS;
	localparam int H  = (WW + 1) / 2;
	localparam int PW = CW + H + 1;
	localparam int AW = CW + SH + 2;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);

	logic signed [PW-1:0] plo_s3 [4];
	logic signed [PW-1:0] phi_s3 [4];
	logic signed [AW-1:0] term_s4 [4];
	logic signed [AW-1:0] sum01_s5;
	logic signed [AW-1:0] sum23_s5;
	logic signed [AW-1:0] total;
	logic [CW-1:0]        point_s6;

	// weight split in two halves keeps each multiplier narrow
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 4; i++) begin
				plo_s3[i] <= PW'($signed(coord[i])) * PW'($signed({1'b0, weight[i][H-1:0]}));
				phi_s3[i] <= PW'($signed(coord[i])) * PW'($signed({1'b0, weight[i][WW-1:H]}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 4; i++) begin
				term_s4[i] <= (AW'(phi_s3[i]) <<< H) + AW'(plo_s3[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			sum01_s5 <= term_s4[0] + term_s4[1];
			sum23_s5 <= term_s4[2] + term_s4[3];
		end
	end

	assign total = sum01_s5 + sum23_s5 + HALF;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			point_s6 <= total[SH +: CW];
		end
	end

	assign point = point_s6;

endmodule

`default_nettype wire

FILE: rtl/core/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator: pipeline control and APB registers.
//
//   channel   dir   handshake                 payload
//   curve     in    curve_valid/curve_stall   curve_param
//   point     out   point_valid/point_stall   point_x, point_y
//   config    in    APB psel/penable/pready   p0..p3 x/y at paddr 4*i
//
// Six register stages form the multiply/add pipeline; it sustains one item per cycle
// while point_stall is low.
// Each stage loads when empty or when the next one moves, so bubbles collapse
// and the input is stalled only when all six stages hold items and point_stall is high.
// Reset clears the stage valid bits and loads the control point reset values.
`default_nettype none

module cubic_bezier_point_eval #(
	parameter int COORD_WIDTH     = cbz_pkg::CBZ_COORD_WIDTH,
	parameter int PARAM_FRAC_BITS = cbz_pkg::CBZ_PARAM_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              curve_valid,
	output logic                                   curve_stall,
	input  wire logic [PARAM_FRAC_BITS-1:0]        curve_param,
	output logic                                   point_valid,
	input  wire logic                              point_stall,
	output logic      [COORD_WIDTH-1:0]            point_x,
	output logic      [COORD_WIDTH-1:0]            point_y,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [cbz_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [cbz_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [cbz_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	localparam int WW = 3*PARAM_FRAC_BITS + 1;

	cbz_pkg::pipe_en_t en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [3:0][COORD_WIDTH-1:0] coord_x;
	logic [3:0][COORD_WIDTH-1:0] coord_y;
	logic [3:0][WW-1:0]          weight;

	always_comb begin
		en.s6 = !vld_s6 || !point_stall;
		en.s5 = !vld_s5 || en.s6;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= curve_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
		end
	end

	assign curve_stall = !en.s1;
	assign point_valid = vld_s6;

	cbz_cfg_regs #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.coord_x(coord_x),
		.coord_y(coord_y)
	);

	cbz_weight_gen #(
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_weight_gen (
		.clk        (clk),
		.en         (en),
		.curve_param(curve_param),
		.weight     (weight)
	);

	cbz_axis_sum #(
		.COORD_WIDTH    (COORD_WIDTH),
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_axis_x (
		.clk   (clk),
		.en    (en),
		.coord (coord_x),
		.weight(weight),
		.point (point_x)
	);

	cbz_axis_sum #(
		.COORD_WIDTH    (COORD_WIDTH),
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_axis_y (
		.clk   (clk),
		.en    (en),
		.coord (coord_y),
		.weight(weight),
		.point (point_y)
	);

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && point_stall)
		|-> curve_stall)
		else $error("input not stalled with full pipeline and stalled output");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(curve_valid && !curve_stall) |=> vld_s1)
		else $error("accepted item did not enter stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall && !vld_s5) |=> !point_valid)
		else $error("output item repeated after being taken");

endmodule

`default_nettype wire
